// ===== design/pamc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamc_pkg
// Shared types and constants of the pixel alpha/mono converter.
// ----------------------------------------------------------------------------
package pamc_pkg;

  localparam int unsigned ChanBits  = 8;
  localparam int unsigned ProdBits  = 2 * ChanBits;
  localparam int unsigned PipeDepth = 6;

  typedef logic [ChanBits-1:0] chan_t;
  typedef logic [ProdBits-1:0] prod_t;

  // configuration register indexes
  localparam logic [1:0] CfgMonoEnable = 2'd0;
  localparam logic [1:0] CfgLumWeighted = 2'd1;
  localparam logic [1:0] CfgTintSelect = 2'd2;

  // tint selector codes
  localparam logic [1:0] TintWhite  = 2'd0;
  localparam logic [1:0] TintGreen  = 2'd1;
  localparam logic [1:0] TintAmber  = 2'd2;
  localparam logic [1:0] TintWhite2 = 2'd3;

  // floor(c * w / 10000) as floor(c * w * Recip >> WeightShift)
  localparam int unsigned WeightShift = 35;
  localparam int unsigned WeightBits  = 35;
  localparam longint unsigned Recip =
    ((64'd1 << WeightShift) + 64'd9999) / 64'd10000;
  localparam logic [WeightBits-1:0] WeightRed   = WeightBits'(64'd2126 * Recip);
  localparam logic [WeightBits-1:0] WeightGreen = WeightBits'(64'd7152 * Recip);
  localparam logic [WeightBits-1:0] WeightBlue  = WeightBits'(64'd722 * Recip);

  function automatic chan_t tint_factor(input logic [1:0] sel, input logic [1:0] ch);
    chan_t f;
    f = 8'hFF;
    case (sel)
      TintGreen: begin
        case (ch)
          2'd0:    f = 8'h4A;
          2'd1:    f = 8'hFF;
          default: f = 8'h00;
        endcase
      end
      TintAmber: begin
        case (ch)
          2'd0:    f = 8'hFF;
          2'd1:    f = 8'hB7;
          default: f = 8'h00;
        endcase
      end
      TintWhite, TintWhite2: f = 8'hFF;
      default:               f = 8'hFF;
    endcase
    return f;
  endfunction

endpackage

// ===== design/pamc_div255.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamc_div255
// Exact floor(p / 255) of a product of two channel values.
// ----------------------------------------------------------------------------
module pamc_div255 (
  input  pamc_pkg::prod_t prod_i,
  output pamc_pkg::chan_t quot_o
);

  logic [pamc_pkg::ProdBits:0] sum;

  assign sum = {1'b0, prod_i} + (pamc_pkg::ProdBits + 1)'(1)
             + (pamc_pkg::ProdBits + 1)'(prod_i >> pamc_pkg::ChanBits);
  assign quot_o = sum[pamc_pkg::ProdBits-1:pamc_pkg::ChanBits];

endmodule

// ===== design/pixel_alpha_mono_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_alpha_mono_converter_top
// Per-pixel alpha scaling when alpha_mode_i is set, then optional luminance conversion with tint.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | sink      | in_valid_i / in_ready_o | red, green, blue, alpha, mode
//   out     | source    | out_valid_o/out_ready_i | out_red, out_green, out_blue
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Six register stages: alpha multiply, divide by 255, luminance terms,
// level, tint multiply, divide by 255 into the output register.
// One pixel per clock while out_ready_i does not stall the output.
// A stalled output holds only the stages that are full; empty stages still fill.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module pixel_alpha_mono_converter_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pamc_pkg::chan_t       red_i,
  input  pamc_pkg::chan_t       green_i,
  input  pamc_pkg::chan_t       blue_i,
  input  pamc_pkg::chan_t       alpha_i,
  input  logic                  alpha_mode_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pamc_pkg::chan_t       out_red_o,
  output pamc_pkg::chan_t       out_green_o,
  output pamc_pkg::chan_t       out_blue_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [1:0]            cfg_data_i
);

  localparam int unsigned Depth = pamc_pkg::PipeDepth;

  function automatic pamc_pkg::chan_t third_approx(input logic [9:0] s);
    logic [9:0] a;
    logic [9:0] b;
    a = s >> 2;
    b = a >> 2;
    a = a + b;
    b = b >> 2;
    a = a + b;
    b = b >> 2;
    a = a + b;
    b = b >> 2;
    a = a + b;
    return a[pamc_pkg::ChanBits-1:0];
  endfunction

  // configuration
  logic       mono_q;
  logic       weighted_q;
  logic [1:0] tint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q     <= 1'b0;
      weighted_q <= 1'b1;
      tint_q     <= pamc_pkg::TintWhite;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pamc_pkg::CfgMonoEnable:  mono_q     <= cfg_data_i[0];
        pamc_pkg::CfgLumWeighted: weighted_q <= cfg_data_i[0];
        pamc_pkg::CfgTintSelect:  tint_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // pipeline control
  logic [Depth:1] vld_q;
  logic [Depth:1] en;

  always_comb begin
    en[Depth] = !vld_q[Depth] || out_ready_i;
    for (int k = Depth - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= Depth; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = vld_q[Depth];

  // datapath
  pamc_pkg::chan_t [2:0] in_pix;
  assign in_pix = {blue_i, green_i, red_i};

  pamc_pkg::chan_t [2:0] s1_pix_q;
  pamc_pkg::prod_t [2:0] s1_prod_q;
  logic                  s1_amode_q;

  pamc_pkg::chan_t [2:0] s2_quot;
  pamc_pkg::chan_t [2:0] s2_pix_q;

  logic [pamc_pkg::WeightBits-1:0] weight_k [3];
  logic [pamc_pkg::WeightBits+pamc_pkg::ChanBits-1:0] s3_wprod [3];
  pamc_pkg::chan_t [2:0] s3_term_q;
  logic [9:0]            s3_sum_q;
  pamc_pkg::chan_t [2:0] s3_pix_q;

  logic [9:0]            s4_wsum;
  pamc_pkg::chan_t       s4_level_q;
  pamc_pkg::chan_t [2:0] s4_pix_q;

  pamc_pkg::prod_t [2:0] s5_prod_q;
  pamc_pkg::chan_t [2:0] s5_pix_q;

  pamc_pkg::chan_t [2:0] s6_quot;
  pamc_pkg::chan_t [2:0] s6_pix_q;

  assign weight_k[0] = pamc_pkg::WeightRed;
  assign weight_k[1] = pamc_pkg::WeightGreen;
  assign weight_k[2] = pamc_pkg::WeightBlue;

  for (genvar i = 0; i < 3; i++) begin : g_chan
    pamc_div255 u_div_alpha (
      .prod_i (s1_prod_q[i]),
      .quot_o (s2_quot[i])
    );
    pamc_div255 u_div_tint (
      .prod_i (s5_prod_q[i]),
      .quot_o (s6_quot[i])
    );
    assign s3_wprod[i] =
      (pamc_pkg::WeightBits + pamc_pkg::ChanBits)'(s2_pix_q[i])
      * (pamc_pkg::WeightBits + pamc_pkg::ChanBits)'(weight_k[i]);
  end

  assign s4_wsum = 10'(s3_term_q[0]) + 10'(s3_term_q[1]) + 10'(s3_term_q[2]);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_pix_q   <= in_pix;
      s1_amode_q <= alpha_mode_i;
      for (int i = 0; i < 3; i++) begin
        s1_prod_q[i] <= pamc_pkg::ProdBits'(in_pix[i]) * pamc_pkg::ProdBits'(alpha_i);
      end
    end
    if (en[2]) begin
      s2_pix_q <= s1_amode_q ? s2_quot : s1_pix_q;
    end
    if (en[3]) begin
      s3_pix_q <= s2_pix_q;
      s3_sum_q <= 10'(s2_pix_q[0]) + 10'(s2_pix_q[1]) + 10'(s2_pix_q[2]);
      for (int i = 0; i < 3; i++) begin
        s3_term_q[i] <= s3_wprod[i][pamc_pkg::WeightShift +: pamc_pkg::ChanBits];
      end
    end
    if (en[4]) begin
      s4_pix_q   <= s3_pix_q;
      s4_level_q <= weighted_q ? s4_wsum[pamc_pkg::ChanBits-1:0] : third_approx(s3_sum_q);
    end
    if (en[5]) begin
      s5_pix_q <= s4_pix_q;
      for (int i = 0; i < 3; i++) begin
        s5_prod_q[i] <= pamc_pkg::ProdBits'(s4_level_q)
                      * pamc_pkg::ProdBits'(pamc_pkg::tint_factor(tint_q, 2'(i)));
      end
    end
    if (en[6]) begin
      s6_pix_q <= mono_q ? s6_quot : s5_pix_q;
    end
  end

  assign out_red_o   = s6_pix_q[0];
  assign out_green_o = s6_pix_q[1];
  assign out_blue_o  = s6_pix_q[2];

endmodule

// ===== design/pamc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamc_checker
// Port-level checks of the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pamc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input pamc_pkg::chan_t out_red_o,
  input pamc_pkg::chan_t out_green_o,
  input pamc_pkg::chan_t out_blue_o
);

  logic [3:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before acceptance");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o))
    else $error("stalled output payload changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 4'd0)
    else $error("output transaction without a pending input");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(pamc_pkg::PipeDepth))
    else $error("more transactions in flight than pipeline stages");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && pend_q == 4'(pamc_pkg::PipeDepth))
    else $error("input stalled while pipeline not full and blocked");

endmodule

bind pixel_alpha_mono_converter_top pamc_checker u_pamc_checker (.*);
